@@ rtl/btl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package btl_pkg;

    // field widths
    localparam int unsigned CmdW     = 1;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned KindW    = 1;
    localparam int unsigned AddrW    = 15;
    localparam int unsigned WordW    = 12;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned CountW   = 8;
    localparam int unsigned FieldW   = 3;
    localparam int unsigned MemSizeW = 16;

    // commands
    localparam logic [CmdW-1:0] CMD_BYTE = 1'b0;
    localparam logic [CmdW-1:0] CMD_END  = 1'b1;

    // result kinds
    localparam logic [KindW-1:0] KIND_WRITE  = 1'b0;
    localparam logic [KindW-1:0] KIND_FINISH = 1'b1;

    // finish status codes
    localparam logic [StatusW-1:0] ST_OK       = 2'd0;
    localparam logic [StatusW-1:0] ST_FORMAT   = 2'd1;
    localparam logic [StatusW-1:0] ST_CHECKSUM = 2'd2;
    localparam logic [StatusW-1:0] ST_RANGE    = 2'd3;

    // special tape frames
    localparam logic [ByteW-1:0] RUBOUT     = 8'o377;
    localparam logic [ByteW-1:0] LEADER_MRK = 8'o200;

    localparam logic [MemSizeW-1:0] MEM_SIZE_RST = 16'd32768;
    localparam logic [CountW-1:0]   COUNT_MAX    = 8'd255;

    // one result item
    typedef struct packed {
        logic [KindW-1:0]   kind;
        logic [AddrW-1:0]   write_address;
        logic [WordW-1:0]   write_data;
        logic [StatusW-1:0] status;
        logic [CountW-1:0]  sections_done;
        logic [WordW-1:0]   start_origin;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/btl_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface btl_in_if import btl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CmdW-1:0]    command;
    logic [ByteW-1:0]   tape_byte;

    modport source (output valid, output command, output tape_byte, input ready);
    modport sink   (input valid, input command, input tape_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/btl_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface btl_out_if import btl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KindW-1:0]   kind;
    logic [AddrW-1:0]   write_address;
    logic [WordW-1:0]   write_data;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  sections_done;
    logic [WordW-1:0]   start_origin;

    modport source (output valid, output kind, output write_address, output write_data,
                    output status, output sections_done, output start_origin, input ready);
    modport sink   (input valid, input kind, input write_address, input write_data,
                    input status, input sections_done, input start_origin, output ready);
endinterface

`default_nettype wire

@@ rtl/bin_tape_loader_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Binary-format paper tape loader. Each transfer on i_in carries one raw tape frame or the
// end-of-input command; the unit filters rubouts and field frames, assembles twelve-bit
// words from frame pairs, tracks origin and checksum, and returns memory writes or a
// final status on o_out. One item is taken every clock cycle while i_in.ready is high;
// its step, compares and twelve-bit adds, is done in the accepting cycle. A result goes
// to the output register, or to the skid register while the output register waits.
// This two-entry stage lets input keep flowing while a result waits; i_in.ready drops
// only when both entries are full. mem_size resets to 32768; the user must write it
// through i_cfg_we and i_cfg_wdata only while the unit is idle, which it does not check.
module bin_tape_loader_unit import btl_pkg::*; (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [MemSizeW-1:0]  i_cfg_wdata,
    btl_in_if.sink              i_in,
    btl_out_if.source           o_out
);

    typedef enum logic [1:0] {
        PH_LEADER = 2'd0,
        PH_LOW    = 2'd1,
        PH_HIGH   = 2'd2
    } t_phase;

    // loader state
    t_phase              r_phase,        n_phase;
    logic                r_rubout,       n_rubout;
    logic [FieldW-1:0]   r_pend_field,   n_pend_field;
    logic [FieldW-1:0]   r_cur_field,    n_cur_field;
    logic [WordW-1:0]    r_origin,       n_origin;
    logic [WordW-1:0]    r_checksum,     n_checksum;
    logic [ByteW-1:0]    r_word_high,    n_word_high;
    logic [ByteW-1:0]    r_word_low,     n_word_low;
    logic [CountW-1:0]   r_sect_count,   n_sect_count;
    logic [WordW-1:0]    r_first_origin, n_first_origin;
    logic                r_stopped,      n_stopped;
    logic [MemSizeW-1:0] r_mem_size;

    // output stage
    logic                r_out_valid;
    t_result             r_out;
    logic                r_skid_valid;
    t_result             r_skid;

    logic                in_fire;
    logic                out_fire;
    logic                res_valid;
    t_result             res;
    logic [ByteW-1:0]    c;
    logic [13:0]         wd;
    logic [15:0]         addr;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign c        = i_in.tape_byte;

    // assembled word and write address
    assign wd   = {r_word_high, 6'b0} | {6'b0, r_word_low};
    assign addr = {1'b0, r_cur_field, r_origin};

    // one step of the loader for the frame on the input
    always_comb begin
        n_phase        = r_phase;
        n_rubout       = r_rubout;
        n_pend_field   = r_pend_field;
        n_cur_field    = r_cur_field;
        n_origin       = r_origin;
        n_checksum     = r_checksum;
        n_word_high    = r_word_high;
        n_word_low     = r_word_low;
        n_sect_count   = r_sect_count;
        n_first_origin = r_first_origin;
        n_stopped      = r_stopped;
        res_valid      = 1'b0;
        res.kind          = KIND_WRITE;
        res.write_address = '0;
        res.write_data    = '0;
        res.status        = ST_OK;
        res.sections_done = r_sect_count;
        res.start_origin  = r_first_origin;

        if (in_fire) begin
            if (i_in.command == CMD_END) begin
                // report and return to start state
                if (!r_stopped) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_FINISH;
                    if (r_phase == PH_LOW || r_phase == PH_HIGH) begin
                        res.status = ST_FORMAT;
                    end else if (r_sect_count != '0) begin
                        res.status = ST_OK;
                    end else begin
                        res.status = ST_FORMAT;
                    end
                end
                n_phase        = PH_LEADER;
                n_rubout       = 1'b0;
                n_pend_field   = '0;
                n_cur_field    = '0;
                n_origin       = '0;
                n_checksum     = '0;
                n_word_high    = '0;
                n_word_low     = '0;
                n_sect_count   = '0;
                n_first_origin = '0;
                n_stopped      = 1'b0;
            end else if (r_stopped) begin
                // ignore frames after a stop
            end else if (r_rubout) begin
                n_rubout = 1'b0;
            end else if (c == RUBOUT) begin
                n_rubout = 1'b1;
            end else if (c > LEADER_MRK) begin
                n_pend_field = c[5:3];
            end else begin
                case (r_phase)
                    PH_LOW: begin
                        n_word_low = c;
                        n_phase    = PH_HIGH;
                    end
                    PH_HIGH: begin
                        if (c == LEADER_MRK) begin
                            // end of section: last word against checksum
                            if (wd[WordW-1:0] != r_checksum) begin
                                n_stopped  = 1'b1;
                                res_valid  = 1'b1;
                                res.kind   = KIND_FINISH;
                                res.status = ST_CHECKSUM;
                            end else begin
                                if (r_sect_count != COUNT_MAX) begin
                                    n_sect_count = r_sect_count + 1'b1;
                                end
                                n_phase      = PH_LEADER;
                                n_checksum   = '0;
                                n_origin     = '0;
                                n_cur_field  = '0;
                                n_pend_field = '0;
                            end
                        end else begin
                            n_checksum = r_checksum + {4'b0, r_word_high}
                                                    + {4'b0, r_word_low};
                            if (wd[13:12] != 2'b00) begin
                                // origin word
                                n_origin = wd[WordW-1:0];
                                if (r_first_origin == '0) begin
                                    n_first_origin = wd[WordW-1:0];
                                end
                                n_cur_field = r_pend_field;
                                n_word_high = c;
                                n_phase     = PH_LOW;
                            end else if (addr >= r_mem_size) begin
                                n_stopped  = 1'b1;
                                res_valid  = 1'b1;
                                res.kind   = KIND_FINISH;
                                res.status = ST_RANGE;
                            end else begin
                                // data word
                                res_valid         = 1'b1;
                                res.kind          = KIND_WRITE;
                                res.write_address = addr[AddrW-1:0];
                                res.write_data    = wd[WordW-1:0];
                                n_origin    = r_origin + 1'b1;
                                n_cur_field = r_pend_field;
                                n_word_high = c;
                                n_phase     = PH_LOW;
                            end
                        end
                    end
                    default: begin
                        // leader scan
                        if (c != '0 && c < LEADER_MRK) begin
                            n_word_high = c;
                            n_phase     = PH_LOW;
                        end
                    end
                endcase
            end
        end
    end

    // loader state and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_LEADER;
            r_rubout       <= 1'b0;
            r_pend_field   <= '0;
            r_cur_field    <= '0;
            r_origin       <= '0;
            r_checksum     <= '0;
            r_word_high    <= '0;
            r_word_low     <= '0;
            r_sect_count   <= '0;
            r_first_origin <= '0;
            r_stopped      <= 1'b0;
            r_mem_size     <= MEM_SIZE_RST;
        end else begin
            r_phase        <= n_phase;
            r_rubout       <= n_rubout;
            r_pend_field   <= n_pend_field;
            r_cur_field    <= n_cur_field;
            r_origin       <= n_origin;
            r_checksum     <= n_checksum;
            r_word_high    <= n_word_high;
            r_word_low     <= n_word_low;
            r_sect_count   <= n_sect_count;
            r_first_origin <= n_first_origin;
            r_stopped      <= n_stopped;
            if (i_cfg_we) begin
                r_mem_size <= i_cfg_wdata;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    // channel connections
    assign i_in.ready          = !r_skid_valid;
    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out.kind;
    assign o_out.write_address = r_out.write_address;
    assign o_out.write_data    = r_out.write_data;
    assign o_out.status        = r_out.status;
    assign o_out.sections_done = r_out.sections_done;
    assign o_out.start_origin  = r_out.start_origin;

endmodule

`default_nettype wire

@@ verif/bin_tape_loader_unit_tb.sv @@
`timescale 1ns / 1ps

module bin_tape_loader_unit_tb import btl_pkg::*; ();

    localparam int TAPE_ITEMS    = 1850;
    localparam int MAX_IDLE      = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int MAX_REPORTS   = 10;
    localparam int WATCHDOG_NS   = 1_000_000;
    localparam int SAT_SECTIONS  = 260;

    typedef enum logic [1:0] {
        TAPE_LEADER = 2'd0,
        TAPE_LOW    = 2'd1,
        TAPE_HIGH   = 2'd2
    } t_tape_phase;

    typedef enum int {SEC_GOOD, SEC_BAD_SUM, SEC_CUT} t_section_mode;

    // one line of the directed tape
    typedef struct packed {
        logic                is_cfg;
        logic [CmdW-1:0]     cmd;
        logic [ByteW-1:0]    frame;
        logic [MemSizeW-1:0] mem_size;
        logic                typed;
        t_result             want;
    } t_tape_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [MemSizeW-1:0] i_cfg_wdata;

    btl_in_if  tape_if ();
    btl_out_if mem_if ();

    bin_tape_loader_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (tape_if),
        .o_out       (mem_if)
    );

    // loader state as the predictor sees it
    t_tape_phase         ld_phase;
    logic                ld_rubout;
    logic [FieldW-1:0]   ld_pfield;
    logic [FieldW-1:0]   ld_cfield;
    logic [WordW-1:0]    ld_origin;
    logic [WordW-1:0]    ld_sum;
    logic [WordW-1:0]    ld_first;
    logic [ByteW-1:0]    ld_high;
    logic [ByteW-1:0]    ld_low;
    logic [CountW-1:0]   ld_sections;
    logic                ld_halted;
    logic [MemSizeW-1:0] ld_mem_size;

    t_result due_results[$];
    int      n_sent;
    int      n_bad;
    bit      src_steady;
    bit      snk_steady;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void start_section();
        ld_phase  = TAPE_LEADER;
        ld_sum    = '0;
        ld_origin = '0;
        ld_cfield = '0;
        ld_pfield = '0;
    endfunction

    function automatic void clear_loader();
        start_section();
        ld_rubout   = 1'b0;
        ld_high     = '0;
        ld_low      = '0;
        ld_sections = '0;
        ld_first    = '0;
        ld_halted   = 1'b0;
    endfunction

    function automatic t_result make_result(input logic [KindW-1:0] kind,
                                            input logic [AddrW-1:0] addr,
                                            input logic [WordW-1:0] data,
                                            input logic [StatusW-1:0] st);
        t_result r;
        r.kind          = kind;
        r.write_address = addr;
        r.write_data    = data;
        r.status        = st;
        r.sections_done = ld_sections;
        r.start_origin  = ld_first;
        return r;
    endfunction

    task automatic loader_predict(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] fr,
                                  output bit got, output t_result res);
        logic [13:0]      word;
        logic [AddrW-1:0] addr;
        got = 1'b0;
        res = '0;
        // end of input reports unless stopped, then always clears
        if (cmd == CMD_END) begin
            if (!ld_halted) begin
                got = 1'b1;
                if (ld_phase != TAPE_LEADER || ld_sections == 0)
                    res = make_result(KIND_FINISH, '0, '0, ST_FORMAT);
                else
                    res = make_result(KIND_FINISH, '0, '0, ST_OK);
            end
            clear_loader();
            return;
        end
        if (ld_halted)
            return;
        // frame filter: rubout skips the next frame, high frames set the field
        if (ld_rubout) begin
            ld_rubout = 1'b0;
            return;
        end
        if (fr == RUBOUT) begin
            ld_rubout = 1'b1;
            return;
        end
        if (fr > LEADER_MRK) begin
            ld_pfield = fr[5:3];
            return;
        end
        case (ld_phase)
            TAPE_LOW: begin
                ld_low   = fr;
                ld_phase = TAPE_HIGH;
            end
            TAPE_HIGH: begin
                word = {ld_high, 6'b0} | {6'b0, ld_low};
                // section end: last word must match the running sum
                if (fr == LEADER_MRK) begin
                    if (ld_sum != word[11:0]) begin
                        ld_halted = 1'b1;
                        got = 1'b1;
                        res = make_result(KIND_FINISH, '0, '0, ST_CHECKSUM);
                    end else begin
                        if (ld_sections != COUNT_MAX)
                            ld_sections = ld_sections + 1'b1;
                        start_section();
                    end
                    return;
                end
                ld_sum = ld_sum + ld_high + ld_low;
                if (word > 14'o7777) begin
                    ld_origin = word[11:0];
                    if (ld_first == '0)
                        ld_first = ld_origin;
                end else begin
                    addr = {ld_cfield, ld_origin};
                    if ({1'b0, addr} >= ld_mem_size) begin
                        ld_halted = 1'b1;
                        got = 1'b1;
                        res = make_result(KIND_FINISH, '0, '0, ST_RANGE);
                        return;
                    end
                    got = 1'b1;
                    res = make_result(KIND_WRITE, addr, word[11:0], ST_OK);
                    ld_origin = ld_origin + 1'b1;
                end
                ld_cfield = ld_pfield;
                ld_high   = fr;
                ld_phase  = TAPE_LOW;
            end
            default: begin
                // leader scan skips blank and marker frames
                if (fr != '0 && fr < LEADER_MRK) begin
                    ld_high  = fr;
                    ld_phase = TAPE_LOW;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------- checking

    function automatic string show(input t_result r);
        return $sformatf("kind %0d addr %05o data %04o status %0d sections %0d origin %04o",
                         r.kind, r.write_address, r.write_data, r.status,
                         r.sections_done, r.start_origin);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result seen;
        t_result want;
        if (i_rst_n === 1'b1 && mem_if.valid === 1'b1 && mem_if.ready === 1'b1) begin
            seen.kind          = mem_if.kind;
            seen.write_address = mem_if.write_address;
            seen.write_data    = mem_if.write_data;
            seen.status        = mem_if.status;
            seen.sections_done = mem_if.sections_done;
            seen.start_origin  = mem_if.start_origin;
            if (due_results.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result: %s", show(seen));
            end else begin
                want = due_results.pop_front();
                if (seen.kind !== want.kind || seen.write_address !== want.write_address ||
                    seen.write_data !== want.write_data || seen.status !== want.status ||
                    seen.sections_done !== want.sections_done ||
                    seen.start_origin !== want.start_origin) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("mismatch at %0t\n  expected %s\n  actual   %s",
                                 $realtime, show(want), show(seen));
                end
            end
        end
    end

    // result side: random stall before every transfer unless snk_steady is set
    initial begin : drain_results
        int stall;
        mem_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = snk_steady ? 0 : $urandom_range(MAX_IDLE, 0);
            if (stall != 0) begin
                mem_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            mem_if.ready <= 1'b1;
            @(posedge i_clk);
            while (mem_if.valid !== 1'b1) @(posedge i_clk);
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic send_item(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] fr,
                             input logic typed, input t_result want);
        int      gap;
        bit      got;
        t_result res;
        gap = src_steady ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap != 0) begin
            tape_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tape_if.valid     <= 1'b1;
        tape_if.command   <= cmd;
        tape_if.tape_byte <= fr;
        @(posedge i_clk);
        while (tape_if.ready !== 1'b1) @(posedge i_clk);
        // transfer done at this edge
        loader_predict(cmd, fr, got, res);
        if (typed)
            due_results.push_back(want);
        else if (got)
            due_results.push_back(res);
        n_sent++;
    endtask

    task automatic feed(input logic [CmdW-1:0] cmd, input logic [ByteW-1:0] fr);
        send_item(cmd, fr, 1'b0, '0);
    endtask

    task automatic feed_frame_raw(input logic [ByteW-1:0] fr);
        feed(CMD_BYTE, fr);
    endtask

    // a tape frame, now and then preceded by a rubout pair or a field frame
    task automatic feed_frame(input logic [ByteW-1:0] fr);
        if ($urandom_range(11, 0) == 0) begin
            if ($urandom_range(1, 0) == 1) begin
                feed(CMD_BYTE, RUBOUT);
                feed(CMD_BYTE, 8'($urandom_range(255, 0)));
            end else begin
                feed(CMD_BYTE, 8'($urandom_range(8'o376, 8'o201)));
            end
        end
        feed_frame_raw(fr);
    endtask

    task automatic send_word(input logic [ByteW-1:0] hi, input logic [ByteW-1:0] lo);
        feed_frame(hi);
        feed_frame(lo);
    endtask

    task automatic set_mem_size(input logic [MemSizeW-1:0] v);
        tape_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        ld_mem_size = v;
        i_cfg_we <= 1'b0;
    endtask

    // leader, origin word, data words, then checksum word and section marker unless cut
    task automatic send_section(input t_section_mode mode);
        logic [WordW-1:0] sum;
        logic [ByteW-1:0] hi;
        logic [ByteW-1:0] lo;
        int               n_words;
        sum = '0;
        repeat ($urandom_range(3, 0))
            feed_frame(($urandom_range(1, 0) == 1) ? 8'o000 :
                       8'($urandom_range(8'o376, 8'o200)));
        hi = 8'o100 | 8'($urandom_range(63, 0));
        lo = 8'($urandom_range(63, 0));
        send_word(hi, lo);
        sum = sum + hi + lo;
        n_words = $urandom_range(6, 0);
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(7, 0) == 0)
                hi = 8'o100 | 8'($urandom_range(63, 0));
            else
                hi = 8'($urandom_range(63, 0));
            // wide low frame goes in unmasked
            lo = ($urandom_range(9, 0) == 0) ? LEADER_MRK : 8'($urandom_range(63, 0));
            send_word(hi, lo);
            sum = sum + hi + lo;
        end
        if (mode == SEC_CUT) begin
            if ($urandom_range(1, 0) == 1)
                feed_frame(8'($urandom_range(63, 0)));
            return;
        end
        if (mode == SEC_BAD_SUM)
            sum = sum + 12'($urandom_range(4095, 1));
        send_word({2'b00, sum[11:6]}, {2'b00, sum[5:0]});
        feed_frame(LEADER_MRK);
    endtask

    task automatic run_tape();
        int            n_sec;
        t_section_mode mode;
        n_sec = $urandom_range(4, 0);
        for (int i = 0; i < n_sec; i++) begin
            case ($urandom_range(15, 0))
                0:       mode = SEC_BAD_SUM;
                1:       mode = SEC_CUT;
                default: mode = SEC_GOOD;
            endcase
            send_section(mode);
            if (mode == SEC_CUT)
                break;
        end
        if ($urandom_range(1, 0) == 1)
            feed_frame(8'o000);
        feed(CMD_END, 8'($urandom_range(255, 0)));
    endtask

    task automatic noise_tape();
        repeat ($urandom_range(40, 4))
            feed(($urandom_range(15, 0) == 0) ? CMD_END : CMD_BYTE,
                 8'($urandom_range(255, 0)));
        feed(CMD_END, 8'($urandom_range(255, 0)));
    endtask

    // enough good sections to drive the section count into saturation
    task automatic saturate_tape();
        repeat (SAT_SECTIONS) begin
            if ($urandom_range(9, 0) == 0) begin
                send_section(SEC_GOOD);
            end else begin
                feed(CMD_BYTE, 8'o100);
                feed(CMD_BYTE, 8'o000);
                feed(CMD_BYTE, LEADER_MRK);
            end
        end
        feed(CMD_END, 8'o000);
    endtask

    function automatic t_tape_row row_item(input logic [CmdW-1:0] cmd,
                                           input logic [ByteW-1:0] fr);
        t_tape_row r;
        r       = '0;
        r.cmd   = cmd;
        r.frame = fr;
        return r;
    endfunction

    function automatic t_tape_row row_fin(input logic [CmdW-1:0] cmd,
                                          input logic [ByteW-1:0] fr,
                                          input logic [StatusW-1:0] st,
                                          input logic [CountW-1:0] sec,
                                          input logic [WordW-1:0] org);
        t_tape_row r;
        r                    = row_item(cmd, fr);
        r.typed              = 1'b1;
        r.want.kind          = KIND_FINISH;
        r.want.status        = st;
        r.want.sections_done = sec;
        r.want.start_origin  = org;
        return r;
    endfunction

    function automatic t_tape_row row_cfg(input logic [MemSizeW-1:0] v);
        t_tape_row r;
        r          = '0;
        r.is_cfg   = 1'b1;
        r.mem_size = v;
        return r;
    endfunction

    initial begin : main
        t_tape_row dir_rows[$];
        int        stop_at;
        bit        sat_done;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        tape_if.valid     <= 1'b0;
        tape_if.command   <= CMD_BYTE;
        tape_if.tape_byte <= '0;
        ld_mem_size = MEM_SIZE_RST;
        clear_loader();
        n_sent   = 0;
        n_bad    = 0;
        sat_done = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed tape
        dir_rows.push_back(row_fin(CMD_END, 8'o000, ST_FORMAT, 8'd0, 12'o0000)); // nothing read
        dir_rows.push_back(row_item(CMD_BYTE, 8'o000));                // blank leader
        dir_rows.push_back(row_item(CMD_BYTE, 8'o200));                // marker leader
        dir_rows.push_back(row_item(CMD_BYTE, 8'o377));                // rubout
        dir_rows.push_back(row_item(CMD_BYTE, 8'o101));                // skipped by rubout
        dir_rows.push_back(row_item(CMD_BYTE, 8'o270));                // field 7
        dir_rows.push_back(row_item(CMD_BYTE, 8'o100));                // origin 0001
        dir_rows.push_back(row_item(CMD_BYTE, 8'o001));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o012));                // data 1234
        dir_rows.push_back(row_item(CMD_BYTE, 8'o034));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o077));                // data 7777
        dir_rows.push_back(row_item(CMD_BYTE, 8'o077));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o003));                // checksum 0345
        dir_rows.push_back(row_item(CMD_BYTE, 8'o045));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o200));                // good section
        dir_rows.push_back(row_fin(CMD_END, 8'o000, ST_OK, 8'd1, 12'o0001));
        dir_rows.push_back(row_cfg(16'd1));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o001));                // wide low frame
        dir_rows.push_back(row_item(CMD_BYTE, 8'o200));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o005));                // write to address 0
        dir_rows.push_back(row_item(CMD_BYTE, 8'o006));
        dir_rows.push_back(row_fin(CMD_BYTE, 8'o007, ST_RANGE, 8'd0, 12'o0000)); // address 1
        dir_rows.push_back(row_item(CMD_BYTE, 8'o123));                // ignored while stopped
        dir_rows.push_back(row_item(CMD_END, 8'o000));                 // silent restart
        dir_rows.push_back(row_item(CMD_BYTE, 8'o001));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o002));
        dir_rows.push_back(row_fin(CMD_BYTE, 8'o200, ST_CHECKSUM, 8'd0, 12'o0000));
        dir_rows.push_back(row_item(CMD_END, 8'o000));
        dir_rows.push_back(row_item(CMD_BYTE, 8'o040));
        dir_rows.push_back(row_fin(CMD_END, 8'o000, ST_FORMAT, 8'd0, 12'o0000)); // mid-word
        dir_rows.push_back(row_cfg(MEM_SIZE_RST));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                set_mem_size(dir_rows[i].mem_size);
            else
                send_item(dir_rows[i].cmd, dir_rows[i].frame, dir_rows[i].typed,
                          dir_rows[i].want);
        end

        // random tapes, memory size changed between them
        stop_at = n_sent + TAPE_ITEMS;
        while (n_sent < stop_at) begin
            src_steady = ($urandom_range(4, 0) == 0);
            snk_steady = ($urandom_range(4, 0) == 0);
            if ($urandom_range(5, 0) == 0) begin
                case ($urandom_range(4, 0))
                    0:       set_mem_size(16'd1);
                    1:       set_mem_size(MEM_SIZE_RST);
                    2:       set_mem_size(16'($urandom_range(32768, 1)));
                    3:       set_mem_size(16'd4096 * 16'($urandom_range(7, 1)));
                    default: set_mem_size(16'($urandom_range(4096, 1)));
                endcase
            end
            if (!sat_done && n_sent > 600) begin
                // full memory so no section stops on a range error
                set_mem_size(MEM_SIZE_RST);
                saturate_tape();
                sat_done = 1'b1;
            end else if ($urandom_range(9, 0) == 0) begin
                noise_tape();
            end else begin
                run_tape();
            end
        end

        // wait for the last results to come out
        tape_if.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_bad == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/btl_pkg.sv
rtl/btl_in_if.sv
rtl/btl_out_if.sv
rtl/bin_tape_loader_unit.sv
verif/bin_tape_loader_unit_tb.sv
